>>> design/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the Base64 decoder
// Character classes, the queue entry passed from the front end to the
// decode back end, and the queue geometry.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Pad character '='
  localparam logic [7:0] PadChar = 8'h3D;

  // Queue between front end and back end
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Class of an incoming character
  typedef enum logic [1:0] {
    CHR_SKIP = 2'd0,  // not in the alphabet, dropped
    CHR_DATA = 2'd1,  // alphabet character, sextet is valid
    CHR_PAD  = 2'd2   // '=' pad character
  } chr_kind_e;

  // Classified item handed to the back end
  typedef struct packed {
    chr_kind_e   kind;
    logic [5:0]  sextet;
    logic        last;
  } chr_item_t;

endpackage

>>> design/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front: input stage of the Base64 decoder
// Accepts one character per cycle while the queue has room, maps it to
// its class and sextet value, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] in_char
  input  logic                 s_axis_tlast,   // last_char
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output b64d_pkg::chr_item_t  item_o
);
  import b64d_pkg::*;

  logic [7:0] c;

  assign c = s_axis_tdata;

  // Take an item whenever the queue has room
  assign s_axis_tready = !fifo_full_i;
  assign push_o        = s_axis_tvalid && !fifo_full_i;

  // Character classification and sextet lookup
  always_comb begin
    item_o.last   = s_axis_tlast;
    item_o.kind   = CHR_DATA;
    item_o.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      item_o.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      item_o.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      item_o.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      item_o.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      item_o.sextet = 6'd63;
    end else if (c == PadChar) begin
      item_o.kind = CHR_PAD;
    end else begin
      item_o.kind = CHR_SKIP;
    end
  end

endmodule

>>> design/b64d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo: short queue of classified characters
// Decouples the input stage from the decode stage so each can stall alone.
// ----------------------------------------------------------------------------
module b64d_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64d_pkg::chr_item_t  push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output b64d_pkg::chr_item_t  pop_item_o
);
  import b64d_pkg::*;

  chr_item_t           mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]     count_q, count_d;

  assign full_o     = (count_q == (FifoAw+1)'(FifoDepth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + FifoAw'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FifoAw'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (FifoAw+1)'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - (FifoAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back: decode stage of the Base64 decoder
// Keeps group phase, previous sextet and the stop flag, builds decoded
// bytes and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  b64d_pkg::chr_item_t  item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
  output logic                 m_axis_tuser,   // byte_valid
  output logic                 m_axis_tlast    // end_of_message
);
  import b64d_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [5:0] prev_q, prev_d;
  logic       stopped_q, stopped_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_bv_q, out_bv_d;
  logic       out_eom_q, out_eom_d;
  logic       have;
  logic [7:0] byte_val;

  // Pop whenever the output register is free or being drained
  assign pop_o = valid_i && (!out_valid_q || m_axis_tready);

  // Decode one item
  always_comb begin
    phase_d   = phase_q;
    prev_d    = prev_q;
    stopped_d = stopped_q;
    have      = 1'b0;
    byte_val  = 8'd0;
    if (!stopped_q) begin
      if (item_i.kind == CHR_PAD && phase_q[1]) begin
        stopped_d = 1'b1;
      end else if (item_i.kind == CHR_DATA) begin
        case (phase_q)
          2'd1: begin
            byte_val = {prev_q, item_i.sextet[5:4]};
            have     = 1'b1;
          end
          2'd2: begin
            byte_val = {prev_q[3:0], item_i.sextet[5:2]};
            have     = 1'b1;
          end
          2'd3: begin
            byte_val = {prev_q[1:0], item_i.sextet};
            have     = 1'b1;
          end
          default: begin
            have = 1'b0;
          end
        endcase
        prev_d  = item_i.sextet;
        phase_d = phase_q + 2'd1;
      end
    end
    // Final character clears the decode state
    if (item_i.last) begin
      phase_d   = 2'd0;
      prev_d    = 6'd0;
      stopped_d = 1'b0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_bv_d    = out_bv_q;
    out_eom_d   = out_eom_q;
    if (pop_o && (have || item_i.last)) begin
      out_valid_d = 1'b1;
      out_byte_d  = byte_val;
      out_bv_d    = have;
      out_eom_d   = item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      prev_q      <= 6'd0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        prev_q    <= prev_d;
        stopped_q <= stopped_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_bv_q   <= out_bv_d;
    out_eom_q  <= out_eom_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_bv_q;
  assign m_axis_tlast  = out_eom_q;

endmodule

>>> design/base64_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder: streaming Base64 decoder
// One character in per item, at most one decoded byte out per item.
// ----------------------------------------------------------------------------
// Takes one character per clock and sustains that rate indefinitely while
// the output side keeps up. A character is classified as it is accepted,
// waits in a four-entry queue and is decoded into an output register: with
// the queue empty and the output register free, the queue entry is its only
// stop before the output register. Characters outside the standard
// alphabet are skipped; an '=' in the third or fourth slot of
// a group ends decoding until the character marked tlast, which always
// yields a result with tlast set (tuser tells whether it carries a byte)
// and returns the decoder to its reset state.
// ----------------------------------------------------------------------------
module base64_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // end_of_message
);
  import b64d_pkg::*;

  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_valid;
  chr_item_t  push_item;
  chr_item_t  pop_item;

  // Classify stage
  b64d_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Queue between the stages
  b64d_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_item_o  (pop_item)
  );

  // Decode stage
  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (fifo_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> sim/tb_base64_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_decoder: self-checking testbench of the Base64 decoder
// A short directed table covers the alphabet extremes, skipped characters,
// pad handling in every slot and end-of-message cases. Random messages
// follow, under several idle and stall mixes. Every result is checked
// field by field against the typed row or else a predictor of the decoder.
// ----------------------------------------------------------------------------
module tb_base64_decoder;
  import b64d_pkg::PadChar;

  localparam int unsigned PhaseItems = 325;  // counted items per random phase
  localparam int unsigned HoldCycles = 60;   // long receiver hold-off
  localparam int unsigned TailCycles = 8;    // settle time after last result
  localparam int unsigned WdogLimit  = 1000; // cycles with no item moving
  localparam logic [6:0]  NoSextet   = 7'h40; // character outside the alphabet

  // One decoder result
  typedef struct packed {
    logic [7:0] data;     // out_byte
    logic       byte_ok;  // byte_valid
    logic       eom;      // end_of_message
  } dec_out_t;

  typedef struct packed {
    logic     fires;
    dec_out_t res;
  } dec_pred_t;

  // Directed row: the expectation is used only when typed is set
  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    logic       fires;
    dec_out_t   want;
  } vec_row_t;

  localparam dec_out_t NoOut = '0;
  localparam int unsigned DirRows = 27;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Typed expectation riding along with the item on the bus
  logic        row_typed;
  logic        row_fires;
  dec_out_t    row_want;

  // Predictor state
  logic [1:0]  grp_slot;
  logic [5:0]  held_sextet;
  logic        halted;

  dec_out_t    pending_out[$];
  int unsigned pending_cnt;
  int unsigned quiet_cycles;
  int unsigned err_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_reqs;
  int unsigned sent_items;

  vec_row_t dir_rows [DirRows] = '{
    // "TWFu" decodes to "Man"
    '{"T",     1'b0, 1'b1, 1'b0, NoOut},
    '{"W",     1'b0, 1'b1, 1'b1, '{8'h4D, 1'b1, 1'b0}},
    '{"F",     1'b0, 1'b1, 1'b1, '{8'h61, 1'b1, 1'b0}},
    '{"u",     1'b0, 1'b1, 1'b1, '{8'h6E, 1'b1, 1'b0}},
    // all-ones group with upper-range characters mixed in
    '{"/",     1'b0, 1'b1, 1'b0, NoOut},
    '{8'hFF,   1'b0, 1'b1, 1'b0, NoOut},
    '{"/",     1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{8'h80,   1'b0, 1'b1, 1'b0, NoOut},
    '{"/",     1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{"/",     1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    // pad in first and second slot is skipped; all-zeros group
    '{PadChar, 1'b0, 1'b1, 1'b0, NoOut},
    '{"A",     1'b0, 1'b1, 1'b0, NoOut},
    '{PadChar, 1'b0, 1'b1, 1'b0, NoOut},
    '{"A",     1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{"A",     1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{"A",     1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    // pad in third slot stops decoding; last item gives an empty result
    '{"+",     1'b0, 1'b0, 1'b0, NoOut},
    '{"9",     1'b0, 1'b0, 1'b0, NoOut},
    '{PadChar, 1'b0, 1'b1, 1'b0, NoOut},
    '{8'h00,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    // last item that also decodes a byte; trailing bits dropped
    '{"S",     1'b0, 1'b0, 1'b0, NoOut},
    '{"G",     1'b1, 1'b0, 1'b0, NoOut},
    // pad in fourth slot, then a character ignored while stopped
    '{"Q",     1'b0, 1'b0, 1'b0, NoOut},
    '{"U",     1'b0, 1'b0, 1'b0, NoOut},
    '{"I",     1'b0, 1'b0, 1'b0, NoOut},
    '{PadChar, 1'b0, 1'b1, 1'b0, NoOut},
    '{"a",     1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}}
  };

  base64_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Alphabet lookup: 6-bit value, or NoSextet
  function automatic logic [6:0] sextet_lookup(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
    if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 8'd26);
    if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 8'd52);
    if (ch == "+") return 7'd62;
    if (ch == "/") return 7'd63;
    return NoSextet;
  endfunction

  // Inverse mapping, for generating well-formed text
  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 6'd26);
    if (v < 6'd62) return 8'("0" + v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // Predictor: advances the decoder state by one character
  function automatic dec_pred_t decode_char(input logic [7:0] ch, input logic lst);
    dec_pred_t  p;
    logic [6:0] sx;
    logic [7:0] b;
    logic       got;
    got = 1'b0;
    b   = '0;
    if (!halted) begin
      sx = sextet_lookup(ch);
      if (ch == PadChar && grp_slot >= 2'd2) begin
        halted = 1'b1;
      end else if (sx != NoSextet) begin
        case (grp_slot)
          2'd1: begin
            b = {held_sextet, sx[5:4]};
            got = 1'b1;
          end
          2'd2: begin
            b = {held_sextet[3:0], sx[5:2]};
            got = 1'b1;
          end
          2'd3: begin
            b = {held_sextet[1:0], sx[5:0]};
            got = 1'b1;
          end
          default: ;
        endcase
        held_sextet = sx[5:0];
        grp_slot    = grp_slot + 2'd1;
      end
    end
    p.fires       = got | lst;
    p.res.data    = b;
    p.res.byte_ok = got;
    p.res.eom     = lst;
    // end of message clears everything
    if (lst) begin
      grp_slot    = '0;
      held_sextet = '0;
      halted      = 1'b0;
    end
    return p;
  endfunction

  // Monitor: predict on input items, check on output items
  always @(posedge clk_i) begin : mon_p
    dec_pred_t pr;
    dec_out_t  got;
    dec_out_t  want;
    logic      in_acc;
    logic      out_acc;
    if (rst_ni) begin
      in_acc  = s_axis_tvalid && s_axis_tready;
      out_acc = m_axis_tvalid && m_axis_tready;
      if (in_acc) begin
        pr = decode_char(s_axis_tdata, s_axis_tlast);
        if (row_typed) begin
          if (row_fires) pending_out.push_back(row_want);
        end else if (pr.fires) begin
          pending_out.push_back(pr.res);
        end
      end
      if (out_acc) begin
        got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
        if (pending_out.size() == 0) begin
          $error("unexpected item: out_byte %02h byte_valid %b end_of_message %b",
                 got.data, got.byte_ok, got.eom);
          err_cnt++;
        end else begin
          want = pending_out.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, got.data);
            err_cnt++;
          end
          if (got.byte_ok !== want.byte_ok) begin
            $error("byte_valid: expected %b, got %b", want.byte_ok, got.byte_ok);
            err_cnt++;
          end
          if (got.eom !== want.eom) begin
            $error("end_of_message: expected %b, got %b", want.eom, got.eom);
            err_cnt++;
          end
        end
      end
      pending_cnt  <= pending_out.size();
      quiet_cycles <= (in_acc || out_acc) ? 0 : quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : rx_p
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < WdogLimit) @(posedge clk_i);
    $display("FAIL base64_decoder");
    $finish;
  end

  // Offer one item and return at the edge that accepts it
  task automatic drive_char(input logic [7:0] ch, input logic lst,
                            input logic typed, input logic fires, input dec_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= lst;
    row_typed     <= typed;
    row_fires     <= fires;
    row_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drive_rand(input logic [7:0] ch, input logic lst);
    drive_char(ch, lst, 1'b0, 1'b0, NoOut);
  endtask

  // Sender pause until every result is in, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // One random message: mostly well-formed, with noise and stray pads
  task automatic send_message();
    int unsigned n;
    int unsigned ending;
    logic [7:0]  ch;
    n = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    ending = $urandom_range(9);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        drive_rand(8'($urandom_range(255)), 1'b0);
        sent_items++;
      end
      if ($urandom_range(99) < 3) begin
        drive_rand(PadChar, 1'b0);
        sent_items++;
      end
      ch = alphabet_char(6'($urandom_range(63)));
      drive_rand(ch, (i == n - 1) && ending < 6);
      sent_items++;
    end
    // message tail: one or two pads, noise, or a lone pad as last item
    if (ending inside {6, 7}) begin
      if (ending == 7) begin
        drive_rand(PadChar, 1'b0);
        sent_items++;
      end
      drive_rand(PadChar, 1'b1);
      sent_items++;
    end else if (ending == 8) begin
      drive_rand(8'($urandom_range(255)), 1'b1);
      sent_items++;
    end else if (ending == 9) begin
      drive_rand(PadChar, 1'b1);
      sent_items++;
    end
  endtask

  // Main sequence
  initial begin
    int unsigned pct_s [4] = '{0, 55, 0, 29};
    int unsigned pct_r [4] = '{0, 0, 55, 29};
    logic        held;
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tlast   <= 1'b0;
    row_typed      <= 1'b0;
    row_fires      <= 1'b0;
    row_want       <= NoOut;
    recv_stall_pct <= 0;
    hold_reqs      <= 0;
    pending_cnt    <= 0;
    quiet_cycles   <= 0;
    send_idle_pct  = 0;
    err_cnt        = 0;
    sent_items     = 0;
    grp_slot       = '0;
    held_sextet    = '0;
    halted         = 1'b0;
    held           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i])
      drive_char(dir_rows[i].ch, dir_rows[i].lst, dir_rows[i].typed,
                 dir_rows[i].fires, dir_rows[i].want);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pct_s[ph];
      recv_stall_pct <= pct_r[ph];
      sent_items     = 0;
      while (sent_items < PhaseItems) begin
        // long receiver hold-off while items keep coming
        if (ph == 0 && !held && sent_items > 80) begin
          hold_reqs <= hold_reqs + 1;
          held = 1'b1;
        end
        send_message();
      end
      drain();
    end

    if (pending_cnt != 0) begin
      $error("%0d expected items never arrived", pending_cnt);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS base64_decoder");
    end else begin
      $display("FAIL base64_decoder");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_decoder.sv
sim/tb_base64_decoder.sv
